@@ rtl/core/cau_pkg.sv @@
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

  // Default number format: signed Q16.16 in a 32-bit word
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // Operation codes carried by in_cmd
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic vld;
    op_t  op;
    logic dz;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

@@ rtl/core/cau_front.sv @@
// Front end: operand capture, six parallel multipliers, sums, sign split, lane preload.
module cau_front #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_cmd,
  input  logic signed [31:0]         in_a_real,
  input  logic signed [31:0]         in_a_imag,
  input  logic signed [31:0]         in_b_real,
  input  logic signed [31:0]         in_b_imag,
  input  logic                       dn_rdy,
  output cau_pkg::ctl_t              ctl_o,
  output logic [2*WORD_BITS-1:0]     den_o,
  output logic [2*WORD_BITS-1:0]     xrem_o,
  output logic [WORD_BITS:0]         xnl_o,
  output logic [WORD_BITS+1:0]       xacc_o,
  output logic [2*WORD_BITS-1:0]     yrem_o,
  output logic [WORD_BITS:0]         ynl_o,
  output logic [WORD_BITS+1:0]       yacc_o,
  output logic [2*WORD_BITS+1:0]     sin_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = 2*W + F;
  localparam int TW = W + F - 1;
  localparam int CW = (TW > 2*W) ? TW : 2*W;

  // Clamp a wide magnitude into W+2 bits; the top bit marks "far out of range"
  function automatic logic [W+1:0] fold(input logic [2*W-1:0] v);
    return {|v[2*W-1:W+1], v[W:0]};
  endfunction

  logic en_a, en_b, en_c, en_d, en_e;

  // Stage A: operand capture
  cau_pkg::ctl_t          a_ctl_r, a_ctl_nxt;
  logic signed [W-1:0]    ar_r, ai_r, br_r, bi_r;

  // Stage B: products
  cau_pkg::ctl_t          b_ctl_r;
  logic signed [W-1:0]    b_ar_r, b_ai_r, b_br_r, b_bi_r;
  logic signed [2*W-1:0]  p_rb_r, p_ib_r, p_rbi_r, p_ibr_r, p_4_r, p_5_r;
  logic signed [2*W-1:0]  p_rb_nxt, p_ib_nxt, p_rbi_nxt, p_ibr_nxt, p_4_nxt, p_5_nxt;
  logic signed [W-1:0]    m4_op, m5_op;

  // Stage C: sums
  cau_pkg::ctl_t          c_ctl_r;
  logic signed [2*W:0]    x_r, y_r, x_nxt, y_nxt;
  logic [2*W-1:0]         den_c_r, den_c_nxt;

  // Stage D: sign and magnitude
  cau_pkg::ctl_t          d_ctl_r, d_ctl_nxt;
  logic [2*W-1:0]         mx_r, my_r, den_d_r;
  logic [2*W:0]           mx_full, my_full;

  // Stage E: lane preload
  cau_pkg::ctl_t          e_ctl_nxt;
  logic [2*W-1:0]         xrem_nxt, yrem_nxt;
  logic [W:0]             xnl_nxt, ynl_nxt;
  logic [W+1:0]           xacc_nxt, yacc_nxt;
  logic [2*W+1:0]         sin_nxt;
  logic [NW-1:0]          nx, ny;
  logic [TW-1:0]          topx, topy;
  logic                   ovfx, ovfy;

  // Ready chain: a stage takes data when empty or when its successor moves
  assign en_e     = !ctl_o.vld   || dn_rdy;
  assign en_d     = !d_ctl_r.vld || en_e;
  assign en_c     = !c_ctl_r.vld || en_d;
  assign en_b     = !b_ctl_r.vld || en_c;
  assign en_a     = !a_ctl_r.vld || en_b;
  assign in_stall = !en_a;

  // Stage A
  always_comb begin
    a_ctl_nxt     = '0;
    a_ctl_nxt.vld = in_valid;
    a_ctl_nxt.op  = cau_pkg::op_t'(in_cmd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else if (en_a) begin
      a_ctl_r <= a_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ar_r <= in_a_real[W-1:0];
      ai_r <= in_a_imag[W-1:0];
      br_r <= in_b_real[W-1:0];
      bi_r <= in_b_imag[W-1:0];
    end
  end

  // Stage B: the squares of B feed the divisor, the squares of A the magnitude
  assign m4_op     = (a_ctl_r.op == cau_pkg::OP_MAG) ? ar_r : br_r;
  assign m5_op     = (a_ctl_r.op == cau_pkg::OP_MAG) ? ai_r : bi_r;
  assign p_rb_nxt  = ar_r * br_r;
  assign p_ib_nxt  = ai_r * bi_r;
  assign p_rbi_nxt = ar_r * bi_r;
  assign p_ibr_nxt = ai_r * br_r;
  assign p_4_nxt   = m4_op * m4_op;
  assign p_5_nxt   = m5_op * m5_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else if (en_b) begin
      b_ctl_r <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_ar_r  <= ar_r;
      b_ai_r  <= ai_r;
      b_br_r  <= br_r;
      b_bi_r  <= bi_r;
      p_rb_r  <= p_rb_nxt;
      p_ib_r  <= p_ib_nxt;
      p_rbi_r <= p_rbi_nxt;
      p_ibr_r <= p_ibr_nxt;
      p_4_r   <= p_4_nxt;
      p_5_r   <= p_5_nxt;
    end
  end

  // Stage C: exact sums per operation
  always_comb begin
    x_nxt = '0;
    y_nxt = '0;
    case (b_ctl_r.op)
      cau_pkg::OP_ADD: begin
        x_nxt = b_ar_r + b_br_r;
        y_nxt = b_ai_r + b_bi_r;
      end
      cau_pkg::OP_SUB: begin
        x_nxt = b_ar_r - b_br_r;
        y_nxt = b_ai_r - b_bi_r;
      end
      cau_pkg::OP_MUL: begin
        x_nxt = p_rb_r - p_ib_r;
        y_nxt = p_rbi_r + p_ibr_r;
      end
      cau_pkg::OP_DIV: begin
        x_nxt = p_rb_r + p_ib_r;
        y_nxt = p_ibr_r - p_rbi_r;
      end
      default: begin
        x_nxt = '0;
        y_nxt = '0;
      end
    endcase
  end

  // Both squares are non-negative and their sum fits 2W unsigned bits
  assign den_c_nxt = $unsigned(p_4_r) + $unsigned(p_5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else if (en_c) begin
      c_ctl_r <= b_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      den_c_r <= den_c_nxt;
    end
  end

  // Stage D: sign and magnitude, divide-by-zero flag
  assign mx_full = x_r[2*W] ? -x_r : x_r;
  assign my_full = y_r[2*W] ? -y_r : y_r;

  always_comb begin
    d_ctl_nxt       = c_ctl_r;
    d_ctl_nxt.neg_x = x_r[2*W];
    d_ctl_nxt.neg_y = y_r[2*W];
    d_ctl_nxt.dz    = (c_ctl_r.op == cau_pkg::OP_DIV) && (den_c_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r <= '0;
    end else if (en_d) begin
      d_ctl_r <= d_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      mx_r    <= mx_full[2*W-1:0];
      my_r    <= my_full[2*W-1:0];
      den_d_r <= den_c_r;
    end
  end

  // Stage E: scaled dividend split into the part above the quotient window and
  // the bits still to be shifted in; a high part at or above the divisor overflows
  assign nx   = NW'(mx_r) << F;
  assign ny   = NW'(my_r) << F;
  assign topx = nx[NW-1:W+1];
  assign topy = ny[NW-1:W+1];
  assign ovfx = CW'(topx) >= CW'(den_d_r);
  assign ovfy = CW'(topy) >= CW'(den_d_r);

  always_comb begin
    e_ctl_nxt = d_ctl_r;
    xrem_nxt  = '0;
    yrem_nxt  = '0;
    xnl_nxt   = '0;
    ynl_nxt   = '0;
    xacc_nxt  = '0;
    yacc_nxt  = '0;
    sin_nxt   = '0;
    case (d_ctl_r.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        xacc_nxt = fold(mx_r);
        yacc_nxt = fold(my_r);
      end
      cau_pkg::OP_MUL: begin
        xacc_nxt = fold(mx_r >> F);
        yacc_nxt = fold(my_r >> F);
      end
      cau_pkg::OP_DIV: begin
        xrem_nxt = ovfx ? '0 : (2*W)'(topx);
        yrem_nxt = ovfy ? '0 : (2*W)'(topy);
        xnl_nxt  = nx[W:0];
        ynl_nxt  = ny[W:0];
        xacc_nxt = {ovfx, {(W+1){1'b0}}};
        yacc_nxt = {ovfy, {(W+1){1'b0}}};
      end
      cau_pkg::OP_MAG: begin
        sin_nxt         = {2'b00, den_d_r};
        e_ctl_nxt.neg_x = 1'b0;
        e_ctl_nxt.neg_y = 1'b0;
      end
      default: begin
        e_ctl_nxt.neg_x = 1'b0;
        e_ctl_nxt.neg_y = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en_e) begin
      ctl_o <= e_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      den_o  <= den_d_r;
      xrem_o <= xrem_nxt;
      xnl_o  <= xnl_nxt;
      xacc_o <= xacc_nxt;
      yrem_o <= yrem_nxt;
      ynl_o  <= ynl_nxt;
      yacc_o <= yacc_nxt;
      sin_o  <= sin_nxt;
    end
  end

endmodule

@@ rtl/core/cau_step.sv @@
// One pipeline step: a quotient bit for both divide lanes and a root bit for magnitude.
module cau_step #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       dn_rdy,
  output logic                       up_rdy,
  input  cau_pkg::ctl_t              ctl_i,
  input  logic [2*WORD_BITS-1:0]     den_i,
  input  logic [2*WORD_BITS-1:0]     xrem_i,
  input  logic [WORD_BITS:0]         xnl_i,
  input  logic [WORD_BITS+1:0]       xacc_i,
  input  logic [2*WORD_BITS-1:0]     yrem_i,
  input  logic [WORD_BITS:0]         ynl_i,
  input  logic [WORD_BITS+1:0]       yacc_i,
  input  logic [WORD_BITS+1:0]       srem_i,
  input  logic [WORD_BITS:0]         sroot_i,
  input  logic [2*WORD_BITS+1:0]     sin_i,
  output cau_pkg::ctl_t              ctl_o,
  output logic [2*WORD_BITS-1:0]     den_o,
  output logic [2*WORD_BITS-1:0]     xrem_o,
  output logic [WORD_BITS:0]         xnl_o,
  output logic [WORD_BITS+1:0]       xacc_o,
  output logic [2*WORD_BITS-1:0]     yrem_o,
  output logic [WORD_BITS:0]         ynl_o,
  output logic [WORD_BITS+1:0]       yacc_o,
  output logic [WORD_BITS+1:0]       srem_o,
  output logic [WORD_BITS:0]         sroot_o,
  output logic [2*WORD_BITS+1:0]     sin_o
);

  localparam int W = WORD_BITS;

  logic              en;
  logic              is_div, is_mag;
  logic [2*W:0]      xsh, ysh, xdif, ydif;
  logic              xge, yge;
  logic [W+3:0]      st, strial, sdif;
  logic              sge;

  logic [2*W-1:0]    xrem_nxt, yrem_nxt;
  logic [W:0]        xnl_nxt, ynl_nxt;
  logic [W+1:0]      xacc_nxt, yacc_nxt;
  logic [W+1:0]      srem_nxt;
  logic [W:0]        sroot_nxt;
  logic [2*W+1:0]    sin_nxt;

  assign en     = !ctl_o.vld || dn_rdy;
  assign up_rdy = en;
  assign is_div = (ctl_i.op == cau_pkg::OP_DIV);
  assign is_mag = (ctl_i.op == cau_pkg::OP_MAG);

  // Restoring division: shift in the next dividend bit, subtract when it fits
  assign xsh  = {xrem_i, xnl_i[W]};
  assign ysh  = {yrem_i, ynl_i[W]};
  assign xdif = xsh - {1'b0, den_i};
  assign ydif = ysh - {1'b0, den_i};
  assign xge  = xsh >= {1'b0, den_i};
  assign yge  = ysh >= {1'b0, den_i};

  // Digit-by-digit square root: bring down two bits, try root*4+1
  assign st     = {srem_i, sin_i[2*W+1:2*W]};
  assign strial = {1'b0, sroot_i, 2'b01};
  assign sdif   = st - strial;
  assign sge    = st >= strial;

  always_comb begin
    xrem_nxt  = xrem_i;
    yrem_nxt  = yrem_i;
    xnl_nxt   = xnl_i;
    ynl_nxt   = ynl_i;
    xacc_nxt  = xacc_i;
    yacc_nxt  = yacc_i;
    srem_nxt  = srem_i;
    sroot_nxt = sroot_i;
    sin_nxt   = sin_i;
    if (is_div) begin
      xrem_nxt = xge ? xdif[2*W-1:0] : xsh[2*W-1:0];
      yrem_nxt = yge ? ydif[2*W-1:0] : ysh[2*W-1:0];
      xnl_nxt  = {xnl_i[W-1:0], 1'b0};
      ynl_nxt  = {ynl_i[W-1:0], 1'b0};
      // top bit is the sticky overflow flag, the rest collects quotient bits
      xacc_nxt = {xacc_i[W+1], xacc_i[W-1:0], xge};
      yacc_nxt = {yacc_i[W+1], yacc_i[W-1:0], yge};
    end
    if (is_mag) begin
      srem_nxt  = sge ? sdif[W+1:0] : st[W+1:0];
      sroot_nxt = {sroot_i[W-1:0], sge};
      sin_nxt   = {sin_i[2*W-1:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_o   <= den_i;
      xrem_o  <= xrem_nxt;
      xnl_o   <= xnl_nxt;
      xacc_o  <= xacc_nxt;
      yrem_o  <= yrem_nxt;
      ynl_o   <= ynl_nxt;
      yacc_o  <= yacc_nxt;
      srem_o  <= srem_nxt;
      sroot_o <= sroot_nxt;
      sin_o   <= sin_nxt;
    end
  end

endmodule

@@ rtl/core/cau_back.sv @@
// Back end: saturation, sign restore, status and the output register.
module cau_back #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   up_rdy,
  input  cau_pkg::ctl_t          ctl_i,
  input  logic [WORD_BITS+1:0]   xacc_i,
  input  logic [WORD_BITS+1:0]   yacc_i,
  input  logic [WORD_BITS:0]     sroot_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_res_real,
  output logic signed [31:0]     out_res_imag,
  output logic [1:0]             out_status
);

  localparam int W = WORD_BITS;

  // Clamp a sign/magnitude value to the signed word; returns {saturated, value}
  function automatic logic [W:0] finish(input logic neg, input logic [W+1:0] m);
    logic [W+1:0] maxp;
    logic [W+1:0] maxn;
    logic [W+1:0] mm;
    logic         s;
    logic [W-1:0] v;
    maxp = {3'b000, {(W-1){1'b1}}};
    maxn = {3'b001, {(W-1){1'b0}}};
    mm   = m;
    s    = 1'b0;
    if (!neg && (m > maxp)) begin
      mm = maxp;
      s  = 1'b1;
    end
    if (neg && (m > maxn)) begin
      mm = maxn;
      s  = 1'b1;
    end
    v = mm[W-1:0];
    if (neg) begin
      v = -v;
    end
    return {s, v};
  endfunction

  logic                en;
  logic [W+1:0]        fm_x;
  logic [W:0]          fin_x, fin_y;
  logic signed [W-1:0] vx, vy;
  logic signed [31:0]  re_nxt, im_nxt;
  logic [1:0]          st_nxt;

  assign en     = !out_valid || !out_stall;
  assign up_rdy = en;

  // Magnitude comes from the root lane, everything else from the x lane
  assign fm_x  = (ctl_i.op == cau_pkg::OP_MAG) ? (W+2)'(sroot_i) : xacc_i;
  assign fin_x = finish(ctl_i.neg_x, fm_x);
  assign fin_y = finish(ctl_i.neg_y, yacc_i);
  assign vx    = fin_x[W-1:0];
  assign vy    = fin_y[W-1:0];

  always_comb begin
    if (ctl_i.dz) begin
      re_nxt = '0;
      im_nxt = '0;
      st_nxt = cau_pkg::ST_DIVZ;
    end else begin
      re_nxt = 32'(vx);
      im_nxt = 32'(vy);
      st_nxt = (fin_x[W] || fin_y[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_real <= re_nxt;
      out_res_imag <= im_nxt;
      out_status   <= st_nxt;
    end
  end

endmodule

@@ rtl/core/complex_arithmetic_unit.sv @@
// Top level of the pipelined complex arithmetic unit.
//
//   Channel  Ports                                      Direction  Handshake
//   input    in_cmd, in_a_real/imag, in_b_real/imag      in         in_valid / in_stall
//   result   out_res_real, out_res_imag, out_status      out        out_valid / out_stall
//
// One item may enter every cycle while in_stall is low; every operation takes the same path.
// Every item passes five front stages, one step per quotient bit (WORD_BITS+1
// steps of the long division) and one output stage.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other state.
// A stall holds only the stages that are full; empty slots still fill up.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
  parameter int WORD_BITS = cau_pkg::WORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_real,
  output logic signed [31:0] out_res_imag,
  output logic [1:0]         out_status
);

  localparam int W  = WORD_BITS;
  localparam int NS = W + 1;

  cau_pkg::ctl_t   ctl_w   [NS+1];
  logic [2*W-1:0]  den_w   [NS+1];
  logic [2*W-1:0]  xrem_w  [NS+1];
  logic [W:0]      xnl_w   [NS+1];
  logic [W+1:0]    xacc_w  [NS+1];
  logic [2*W-1:0]  yrem_w  [NS+1];
  logic [W:0]      ynl_w   [NS+1];
  logic [W+1:0]    yacc_w  [NS+1];
  logic [W+1:0]    srem_w  [NS+1];
  logic [W:0]      sroot_w [NS+1];
  logic [2*W+1:0]  sin_w   [NS+1];
  logic            rdy_w   [NS+1];

  // Operands, products, sums and lane preload
  cau_front #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_a_real (in_a_real),
    .in_a_imag (in_a_imag),
    .in_b_real (in_b_real),
    .in_b_imag (in_b_imag),
    .dn_rdy    (rdy_w[0]),
    .ctl_o     (ctl_w[0]),
    .den_o     (den_w[0]),
    .xrem_o    (xrem_w[0]),
    .xnl_o     (xnl_w[0]),
    .xacc_o    (xacc_w[0]),
    .yrem_o    (yrem_w[0]),
    .ynl_o     (ynl_w[0]),
    .yacc_o    (yacc_w[0]),
    .sin_o     (sin_w[0])
  );

  // Root lane starts empty
  assign srem_w[0]  = '0;
  assign sroot_w[0] = '0;

  // Division / square-root steps, one bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_step
    cau_step #(
      .WORD_BITS (W)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .dn_rdy  (rdy_w[i+1]),
      .up_rdy  (rdy_w[i]),
      .ctl_i   (ctl_w[i]),
      .den_i   (den_w[i]),
      .xrem_i  (xrem_w[i]),
      .xnl_i   (xnl_w[i]),
      .xacc_i  (xacc_w[i]),
      .yrem_i  (yrem_w[i]),
      .ynl_i   (ynl_w[i]),
      .yacc_i  (yacc_w[i]),
      .srem_i  (srem_w[i]),
      .sroot_i (sroot_w[i]),
      .sin_i   (sin_w[i]),
      .ctl_o   (ctl_w[i+1]),
      .den_o   (den_w[i+1]),
      .xrem_o  (xrem_w[i+1]),
      .xnl_o   (xnl_w[i+1]),
      .xacc_o  (xacc_w[i+1]),
      .yrem_o  (yrem_w[i+1]),
      .ynl_o   (ynl_w[i+1]),
      .yacc_o  (yacc_w[i+1]),
      .srem_o  (srem_w[i+1]),
      .sroot_o (sroot_w[i+1]),
      .sin_o   (sin_w[i+1])
    );
  end

  // Saturation and output register
  cau_back #(
    .WORD_BITS (W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_rdy       (rdy_w[NS]),
    .ctl_i        (ctl_w[NS]),
    .xacc_i       (xacc_w[NS]),
    .yacc_i       (yacc_w[NS]),
    .sroot_i      (sroot_w[NS]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_real (out_res_real),
    .out_res_imag (out_res_imag),
    .out_status   (out_status)
  );

endmodule

@@ rtl/core/cau_check.sv @@
// Port-level checks of the complex arithmetic unit, bound to the top level.
module cau_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_res_real,
  input logic signed [31:0] out_res_imag,
  input logic [1:0]         out_status
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_real)
      && $stable(out_res_imag) && $stable(out_status))
    else $error("stalled result item changed");

  // With the output free, the whole pipeline moves and input is taken
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output side is free");

  // Divide by zero gives a zero result
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cau_pkg::ST_DIVZ) |-> (out_res_real == '0)
      && (out_res_imag == '0))
    else $error("divide by zero with nonzero result");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind complex_arithmetic_unit cau_check u_cau_check (.*);
